// File: rtl/bati_pkg.sv
// Package for the bounded ASCII-to-integer unit: widths, character codes,
// parse phase type, result struct and digit decoding.
// No dependencies.
package bati_pkg;

    localparam int MAX_LEN = 4096;
    localparam int CH_W    = 8;
    localparam int BASE_W  = 6;
    localparam int VALUE_W = 64;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int OUT_W   = ((VALUE_W + POS_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0]  POS_MAX   = POS_W'(MAX_LEN);

    localparam logic [CH_W-1:0]   CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0]   CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0]   CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0]   CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0]   CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0]   CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0]   CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0]   CH_LOW_X  = 8'h78;
    localparam logic [CH_W-1:0]   CH_UP_X   = 8'h58;
    localparam logic [CH_W-1:0]   CH_LOW_A  = 8'h61;
    localparam logic [CH_W-1:0]   CH_LOW_F  = 8'h66;
    localparam logic [CH_W-1:0]   CH_UP_A   = 8'h41;
    localparam logic [CH_W-1:0]   CH_UP_F   = 8'h46;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_START  = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic              ok;
        logic [3:0]        val;
    } digit_t;

    typedef struct packed {
        logic [POS_W-1:0]   end_offset;
        logic [VALUE_W-1:0] value;
    } result_t;

    function automatic digit_t digit_of(input logic [CH_W-1:0] c);
        digit_t d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
            d.val = 4'(c - CH_ZERO);
        else if (c >= CH_LOW_A && c <= CH_LOW_F)
            d.val = 4'(c - CH_LOW_A + 8'd10);
        else if (c >= CH_UP_A && c <= CH_UP_F)
            d.val = 4'(c - CH_UP_A + 8'd10);
        else
            d.ok = 1'b0;
        return d;
    endfunction

endpackage

// File: rtl/bati_core.sv
// Parse state and combinational next-state logic: whitespace, sign, prefix,
// digit multiply-accumulate. Depends on bati_pkg.
module bati_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [bati_pkg::CH_W-1:0]   ch,
    input  logic                        last,
    input  logic [bati_pkg::BASE_W-1:0] number_base,
    output bati_pkg::result_t           result
);
    import bati_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    stop_reg, stop_next;

    digit_t              dig;
    logic                is_ws;
    logic                auto_or_hex;
    logic                use_digit;
    logic [BASE_W-1:0]   dig_base;
    logic [VALUE_W-1:0]  mac;

    assign dig         = digit_of(ch);
    assign is_ws       = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    assign auto_or_hex = (number_base == BASE_AUTO) || (number_base == BASE_HEX);
    assign mac         = VALUE_W'(acc_reg * dig_base) + VALUE_W'(dig.val);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        stop_next  = stop_reg;
        acc_next   = acc_reg;
        use_digit  = 1'b0;
        dig_base   = base_reg;
        pos_next   = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;

        unique case (phase_reg)
            PH_SPACE, PH_START:
            begin
                if (phase_reg == PH_SPACE && is_ws)
                    stop_next = pos_next;
                else if (phase_reg == PH_SPACE && (ch == CH_MINUS || ch == CH_PLUS))
                begin
                    neg_next   = (ch == CH_MINUS);
                    phase_next = PH_START;
                    stop_next  = pos_next;
                end
                else if (auto_or_hex && ch == CH_ZERO && !last)
                begin
                    phase_next = PH_ZERO;
                    stop_next  = pos_next;
                end
                else
                begin
                    use_digit = 1'b1;
                    dig_base  = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
                end
            end
            PH_ZERO:
            begin
                if ((ch == CH_LOW_X || ch == CH_UP_X) && !last)
                begin
                    base_next  = BASE_HEX;
                    phase_next = PH_DIGITS;
                    stop_next  = pos_next;
                end
                else
                begin
                    use_digit = 1'b1;
                    dig_base  = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                end
            end
            PH_DIGITS:
            begin
                use_digit = 1'b1;
                dig_base  = base_reg;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (use_digit)
        begin
            base_next = dig_base;
            if (dig.ok && {2'b00, dig.val} < dig_base)
            begin
                phase_next = PH_DIGITS;
                acc_next   = mac;
                stop_next  = pos_next;
            end
            else
                phase_next = PH_DONE;
        end

        result.value      = neg_next ? VALUE_W'(0) - acc_next : acc_next;
        result.end_offset = stop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            base_reg  <= '0;
            pos_reg   <= '0;
            stop_reg  <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                phase_reg <= PH_SPACE;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
                base_reg  <= '0;
                pos_reg   <= '0;
                stop_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                pos_reg   <= pos_next;
                stop_reg  <= stop_next;
            end
        end
    end

endmodule

// File: rtl/bounded_ascii_to_integer_unit.sv
// Bounded ASCII-to-integer unit: input item register, parse core, result
// register and base register. Depends on bati_pkg and bati_core.
// The result register captures the parse result when the last character advances from the input item register.
// Throughput: one character per cycle, stalled only while a result waits.
// Reset: parse state cleared, number_base reads 0 (automatic radix).
module bounded_ascii_to_integer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] ch
    input  logic                        s_tlast,   // last
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bati_pkg::OUT_W-1:0]  m_tdata,   // [63:0] value, [76:64] end_offset
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bati_pkg::BASE_W-1:0] cfg_data   // number_base
);
    import bati_pkg::*;

    logic              in_valid_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              last_reg;
    logic [BASE_W-1:0] base_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           result;
    logic              advance;

    assign advance   = in_valid_reg && (!last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_W'(out_reg);

    bati_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .ch          (ch_reg),
        .last        (last_reg),
        .number_base (base_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= BASE_AUTO;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance && last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
                base_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ch_reg   <= s_tdata;
            last_reg <= s_tlast;
        end
        if (advance && last_reg)
            out_reg <= result;
    end

endmodule
